### sv/acmr_pkg.sv
// Shared constants, register codes and the float-to-PCM rounding function.
`default_nettype none
package acmr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W        = 32;
	localparam int PCM_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 21;
	localparam int MAX_RESULTS   = 4;
	localparam int CNT_W         = 3;

	// Product of a 24-bit float mantissa by the 15-bit scale.
	localparam int FP_MANT_W = 24;
	localparam int FP_PROD_W = 39;
	localparam logic [14:0] FLOAT_SCALE = 15'd32767;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 2'd3;

	// Sample formats
	localparam logic [1:0] FMT_FLOAT32 = 2'd0;
	localparam logic [1:0] FMT_INT32   = 2'd1;
	localparam logic [1:0] FMT_INT16   = 2'd2;

	// Register reset values
	localparam logic [1:0]  RST_SAMPLE_FORMAT = FMT_FLOAT32;
	localparam logic        RST_STEREO_MODE   = 1'b1;
	localparam logic [20:0] RST_PHASE_STEP    = 21'd196608;
	localparam logic [15:0] RST_OUTPUT_LIMIT  = 16'd4096;

	// Finish a float32 word into PCM, given p = mantissa * 32767.
	// Round p to 24 significant bits, then drop the exponent shift.
	function automatic logic signed [PCM_W-1:0] float_to_pcm(
		input logic [WORD_W-1:0]    w,
		input logic [FP_PROD_W-1:0] p
	);
		logic [7:0]        expo;
		logic [22:0]       frac;
		logic [23:0]       q;
		logic              rup;
		logic [24:0]       qr;
		logic [7:0]        dsh;
		logic [7:0]        k;
		logic [24:0]       sh;
		logic [PCM_W-1:0]  mag;
		expo = w[30:23];
		frac = w[22:0];
		mag  = '0;
		if (expo == 8'hFF && frac != 23'd0) begin
			mag = '0;
		end else if (expo >= 8'd127) begin
			mag = 16'd32767;
		end else if (expo == 8'd0) begin
			// subnormals scale far below one LSB
			mag = '0;
		end else begin
			if (p[38]) begin
				q   = p[38:15];
				rup = (p[14:0] > 15'h4000) || (p[14:0] == 15'h4000 && q[0]);
				dsh = 8'd15;
			end else begin
				q   = p[37:14];
				rup = (p[13:0] > 14'h2000) || (p[13:0] == 14'h2000 && q[0]);
				dsh = 8'd14;
			end
			qr  = {1'b0, q} + {24'd0, rup};
			k   = 8'd150 - expo - dsh;
			sh  = qr >> k;
			mag = (sh > 25'd32767) ? 16'd32767 : sh[15:0];
		end
		return w[31] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage
`default_nettype wire

### sv/audio_capture_to_mono_resampler.sv
// Frame to mono PCM converter with linear-interpolation resampling.
// An item is taken only in idle; a silent frame goes straight to a zero output,
// any other frame through conversion on the shared multiplier and then a loop
// step per output, for up to four outputs per item. An output waits on out_ready,
// and each result shows on the output register the cycle after it is formed.
// Reset (arst_n low) clears control state and loads the register defaults.
`default_nettype none
module audio_capture_to_mono_resampler #(
	parameter int FRAC_BITS = acmr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [acmr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [acmr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [acmr_pkg::WORD_W-1:0]         left_word,
	input  wire logic [acmr_pkg::WORD_W-1:0]         right_word,
	input  wire logic                                buffer_end,
	input  wire logic                                silent_buffer,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [acmr_pkg::PCM_W-1:0]        out_sample,
	output logic                                     run_last,
	output logic                                     buffer_last
);

	localparam int POS_W = (FRAC_BITS + 2 > 22) ? FRAC_BITS + 2 : 22;
	localparam int MA_W  = acmr_pkg::FP_MANT_W + 1;
	localparam int MB_W  = (FRAC_BITS > 15) ? FRAC_BITS : 15;
	localparam int P_W   = MA_W + MB_W + 1;
	localparam int V_W   = FRAC_BITS + 19;
	localparam int PCM_W = acmr_pkg::PCM_W;

	localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
	localparam logic [POS_W-1:0] TWO_POS  = ONE_POS << 1;
	localparam logic [POS_W-1:0] STEP_MIN = ONE_POS >> 1;
	localparam logic [V_W-1:0]   RND_NEG  = (V_W'(1) << FRAC_BITS) - V_W'(1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL_L = 4'd1;
	localparam logic [3:0] ST_CVT_L = 4'd2;
	localparam logic [3:0] ST_MUL_R = 4'd3;
	localparam logic [3:0] ST_CVT_R = 4'd4;
	localparam logic [3:0] ST_MIX   = 4'd5;
	localparam logic [3:0] ST_ILOOP = 4'd6;
	localparam logic [3:0] ST_IOUT  = 4'd7;
	localparam logic [3:0] ST_TLOOP = 4'd8;
	localparam logic [3:0] ST_TOUT  = 4'd9;
	localparam logic [3:0] ST_SOUT  = 4'd10;

	// configuration
	logic [1:0]  sample_format_q;
	logic        stereo_mode_q;
	logic [20:0] phase_step_q;
	logic [15:0] output_limit_q;

	// sequencer and frame state
	logic [3:0]                  state_q;
	logic                        buffer_start_q;
	logic                        first_q;
	logic                        end_q;
	logic [POS_W-1:0]            pos_q;
	logic [15:0]                 emitted_q;
	logic [acmr_pkg::CNT_W-1:0]  n_q;
	logic signed [PCM_W-1:0]     prev_q;

	// payload
	logic [acmr_pkg::WORD_W-1:0] left_q;
	logic [acmr_pkg::WORD_W-1:0] right_q;
	logic signed [PCM_W-1:0]     pcm_l_q;
	logic signed [PCM_W-1:0]     pcm_r_q;
	logic signed [PCM_W-1:0]     cur_q;
	logic signed [P_W-1:0]       prod_q;

	// output register
	logic                        out_valid_q;
	logic signed [PCM_W-1:0]     out_sample_q;
	logic                        run_last_q;
	logic                        buffer_last_q;

	logic [acmr_pkg::WORD_W-1:0] src_word;
	logic signed [MA_W-1:0]      mul_a;
	logic [MB_W-1:0]             mul_b;
	logic signed [P_W-1:0]       mul_p;
	logic signed [PCM_W-1:0]     cvt_pcm;
	logic signed [PCM_W:0]       mix_sum;
	logic signed [PCM_W:0]       mix_adj;
	logic signed [PCM_W-1:0]     mix_val;
	logic signed [PCM_W:0]       diff;
	logic signed [V_W-1:0]       interp_v;
	logic signed [V_W-1:0]       interp_t;
	logic signed [PCM_W-1:0]     interp_s;
	logic [POS_W-1:0]            step_ext;
	logic [POS_W-1:0]            step_eff;
	logic                        slot_free;
	logic                        emit_ok;
	logic                        more;
	logic [16:0]                 emitted_nx;
	logic                        res_last;
	logic                        res_blast;
	logic signed [PCM_W-1:0]     res_sample;
	logic                        emit_state;
	logic                        proceed;
	logic                        accept;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign run_last    = run_last_q;
	assign buffer_last = buffer_last_q;

	assign step_ext = POS_W'(phase_step_q);
	assign step_eff = (step_ext < STEP_MIN) ? STEP_MIN : step_ext;

	// shared multiplier: float mantissa scaling, then interpolation weight
	assign src_word = (state_q == ST_MUL_L || state_q == ST_CVT_L) ? left_q : right_q;
	assign diff     = {cur_q[PCM_W-1], cur_q} - {prev_q[PCM_W-1], prev_q};

	always_comb begin
		if (state_q == ST_ILOOP) begin
			mul_a = MA_W'(diff);
			mul_b = MB_W'(pos_q[FRAC_BITS-1:0]);
		end else begin
			mul_a = $signed({1'b0, (src_word[30:23] != 8'd0), src_word[22:0]});
			mul_b = MB_W'(acmr_pkg::FLOAT_SCALE);
		end
	end

	assign mul_p = mul_a * $signed({1'b0, mul_b});

	always_comb begin
		case (sample_format_q)
			acmr_pkg::FMT_FLOAT32:
				cvt_pcm = acmr_pkg::float_to_pcm(src_word, prod_q[acmr_pkg::FP_PROD_W-1:0]);
			acmr_pkg::FMT_INT32: cvt_pcm = $signed(src_word[31:16]);
			acmr_pkg::FMT_INT16: cvt_pcm = $signed(src_word[15:0]);
			default:             cvt_pcm = '0;
		endcase
	end

	// average truncates toward zero: bias negative sums by one before the shift
	assign mix_sum = {pcm_l_q[PCM_W-1], pcm_l_q} + {pcm_r_q[PCM_W-1], pcm_r_q};
	assign mix_adj = mix_sum + (mix_sum[PCM_W] ? (PCM_W+1)'(1) : (PCM_W+1)'(0));
	assign mix_val = stereo_mode_q ? mix_adj[PCM_W:1] : pcm_l_q;

	// prev*(1-f) + cur*f = prev<<F + (cur-prev)*f, truncated toward zero
	assign interp_v = $signed({{(V_W-PCM_W-FRAC_BITS){prev_q[PCM_W-1]}}, prev_q,
	                           {FRAC_BITS{1'b0}}}) + $signed(prod_q[V_W-1:0]);
	assign interp_t = interp_v[V_W-1] ? interp_v + $signed(RND_NEG) : interp_v;
	assign interp_s = interp_t[FRAC_BITS+PCM_W-1:FRAC_BITS];

	// result lookahead: does another output of this frame follow?
	always_comb begin
		case (state_q)
			ST_IOUT: begin
				more       = (pos_q < ONE_POS) || (end_q && pos_q < TWO_POS);
				res_sample = interp_s;
			end
			ST_TOUT: begin
				more       = (pos_q < ONE_POS);
				res_sample = cur_q;
			end
			default: begin
				more       = 1'b0;
				res_sample = '0;
			end
		endcase
	end

	assign emitted_nx = {1'b0, emitted_q} + 17'd1;
	assign emit_ok    = (emitted_q < output_limit_q) &&
	                    (n_q < acmr_pkg::CNT_W'(acmr_pkg::MAX_RESULTS));
	assign res_last   = !(more && (emitted_nx < {1'b0, output_limit_q}) &&
	                      (n_q + 1'b1 < acmr_pkg::CNT_W'(acmr_pkg::MAX_RESULTS)));
	assign res_blast  = (emitted_nx == {1'b0, output_limit_q}) || (res_last && end_q);
	assign slot_free  = !out_valid_q || out_ready;
	assign emit_state = (state_q == ST_IOUT) || (state_q == ST_TOUT) ||
	                    (state_q == ST_SOUT);
	assign proceed    = !emit_ok || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_format_q <= acmr_pkg::RST_SAMPLE_FORMAT;
			stereo_mode_q   <= acmr_pkg::RST_STEREO_MODE;
			phase_step_q    <= acmr_pkg::RST_PHASE_STEP;
			output_limit_q  <= acmr_pkg::RST_OUTPUT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				acmr_pkg::REG_SAMPLE_FORMAT: sample_format_q <= cfg_data[1:0];
				acmr_pkg::REG_STEREO_MODE:   stereo_mode_q   <= cfg_data[0];
				acmr_pkg::REG_PHASE_STEP:    phase_step_q    <= cfg_data[20:0];
				acmr_pkg::REG_OUTPUT_LIMIT:  output_limit_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			buffer_start_q <= 1'b1;
			first_q        <= 1'b0;
			end_q          <= 1'b0;
			pos_q          <= '0;
			emitted_q      <= '0;
			n_q            <= '0;
			prev_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_q        <= buffer_start_q;
						buffer_start_q <= buffer_end;
						end_q          <= buffer_end;
						n_q            <= '0;
						if (buffer_start_q) begin
							emitted_q <= '0;
							pos_q     <= '0;
						end
						state_q <= silent_buffer ? ST_SOUT : ST_MUL_L;
					end
				end
				ST_MUL_L: state_q <= ST_CVT_L;
				ST_CVT_L: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_CVT_R;
				ST_CVT_R: state_q <= ST_MIX;
				ST_MIX: begin
					if (!first_q) begin
						state_q <= ST_ILOOP;
					end else begin
						prev_q  <= mix_val;
						state_q <= end_q ? ST_TLOOP : ST_IDLE;
					end
				end
				ST_ILOOP: begin
					if (pos_q < ONE_POS) begin
						pos_q   <= pos_q + step_eff;
						state_q <= ST_IOUT;
					end else begin
						// rebase the phase onto the new frame
						pos_q   <= pos_q - ONE_POS;
						prev_q  <= cur_q;
						state_q <= end_q ? ST_TLOOP : ST_IDLE;
					end
				end
				ST_TLOOP: begin
					if (pos_q < ONE_POS) begin
						pos_q   <= pos_q + step_eff;
						state_q <= ST_TOUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_IOUT: if (proceed) state_q <= ST_ILOOP;
				ST_TOUT: if (proceed) state_q <= ST_TLOOP;
				ST_SOUT: if (proceed) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (emit_state && emit_ok && slot_free) begin
				out_valid_q <= 1'b1;
				emitted_q   <= emitted_q + 16'd1;
				n_q         <= n_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= left_word;
			right_q <= right_word;
		end
		if (state_q == ST_MUL_L || state_q == ST_MUL_R || state_q == ST_ILOOP)
			prod_q <= mul_p;
		if (state_q == ST_CVT_L)
			pcm_l_q <= cvt_pcm;
		if (state_q == ST_CVT_R)
			pcm_r_q <= cvt_pcm;
		if (state_q == ST_MIX)
			cur_q <= mix_val;
		if (emit_state && emit_ok && slot_free) begin
			out_sample_q  <= (state_q == ST_SOUT) ? '0 : res_sample;
			run_last_q    <= res_last;
			buffer_last_q <= res_blast;
		end
	end

endmodule
`default_nettype wire
